### src/assert_macros.svh
// Assertion macros used by the checker file of the traffic light controller.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: lbl");

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

### src/dtlc_pkg.sv
// Types, constants and helper functions of the traffic light controller.
// No dependencies; every module file of the project imports it.
`default_nettype none
package dtlc_pkg;

   localparam int MAX_APPROACHES = 4;
   localparam int CAR_INPUTS     = 4;
   localparam int NUM_LANES      = (MAX_APPROACHES < CAR_INPUTS) ? MAX_APPROACHES : CAR_INPUTS;
   localparam int LANE_W         = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

   localparam int CAR_W   = 8;
   localparam int PHASE_W = 16;
   localparam int ROT_W   = 8;
   localparam int APPR_W  = 3;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 16;
   localparam int REQ_DW  = 4 * CAR_W;
   localparam int RSP_DW  = 8;
   localparam int DIV_CW  = $clog2(PHASE_W);

   localparam logic [PHASE_W-1:0] INTERVAL_RST     = PHASE_W'(60);
   localparam logic [PHASE_W-1:0] LAG_RST          = '0;
   localparam logic [ROT_W-1:0]   ROTATE_RST       = ROT_W'(10);
   localparam logic [APPR_W-1:0]  NUM_APPR_RST     = APPR_W'(4);
   localparam logic [APPR_W-1:0]  INIT_GREEN_RST   = APPR_W'(2);
   localparam logic [APPR_W-1:0]  MAX_APPR_CODE    = APPR_W'(MAX_APPROACHES);
   localparam logic [APPR_W-1:0]  LANE_LIMIT_CODE  = APPR_W'(NUM_LANES);

   typedef enum logic [CSR_AW-1:0] {
      REG_INTERVAL     = 3'd0,
      REG_LAG_PHASE    = 3'd1,
      REG_ROTATE_EVERY = 3'd2,
      REG_NUM_APPR     = 3'd3,
      REG_INIT_GREEN   = 3'd4
   } csr_reg_type;

   // One lane's finding: does it take part, its count and its place
   typedef struct packed {
      logic              valid;
      logic [CAR_W-1:0]  count;
      logic [LANE_W-1:0] idx;
   } cand_type;

   // Control between the top level and the lag reduction unit
   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;

   function automatic logic [APPR_W-1:0] clamp_green(input logic [APPR_W-1:0] v);
      logic [APPR_W-1:0] r;
      r = v;
      if (v == '0) r = APPR_W'(1);
      else if (v > MAX_APPR_CODE) r = MAX_APPR_CODE;
      return r;
   endfunction

   function automatic logic [APPR_W-1:0] approaches_in_use(input logic [APPR_W-1:0] v);
      logic [APPR_W-1:0] r;
      r = v;
      if (v == '0) r = APPR_W'(1);
      else if (v > LANE_LIMIT_CODE) r = LANE_LIMIT_CODE;
      return r;
   endfunction

   // Keep a unless b is in use and holds strictly more cars: low index wins ties
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type r;
      r = a;
      if (b.valid && (!a.valid || (b.count > a.count))) r = b;
      return r;
   endfunction

endpackage
`default_nettype wire

### src/dtlc_lane.sv
// One approach lane: qualifies its car count against the approaches in use.
// Depends on dtlc_pkg.
`default_nettype none
module dtlc_lane (
   input  wire logic [dtlc_pkg::CAR_W-1:0]  cars,
   input  wire logic [dtlc_pkg::LANE_W-1:0] lane_idx,
   input  wire logic [dtlc_pkg::APPR_W-1:0] n_use,
   output dtlc_pkg::cand_type               cand
);
   import dtlc_pkg::*;

   always_comb begin
      cand.valid = ({1'b0, lane_idx} < (LANE_W+1)'(n_use));
      cand.count = cars;
      cand.idx   = lane_idx;
   end

endmodule
`default_nettype wire

### src/dtlc_merge.sv
// Merge tree over the lane findings: busiest approach, lowest index on a tie.
// Depends on dtlc_pkg.
`default_nettype none
module dtlc_merge (
   input  dtlc_pkg::cand_type                      lanes [dtlc_pkg::NUM_LANES],
   output logic [dtlc_pkg::LANE_W-1:0]             best_idx
);
   import dtlc_pkg::*;

   cand_type level [NUM_LANES];

   // Fold pairwise, level by level, so the lower index stays on the left of every compare
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         level[i] = lanes[i];
      end
      for (int step = 1; step < NUM_LANES; step = step * 2) begin
         for (int i = 0; i + step < NUM_LANES; i = i + 2 * step) begin
            level[i] = pick(level[i], level[i+step]);
         end
      end
      best_idx = level[0].idx;
   end

endmodule
`default_nettype wire

### src/dtlc_lagmod.sv
// Bit-serial remainder unit: reduces lag_phase modulo the interval.
// Depends on dtlc_pkg.
`default_nettype none
module dtlc_lagmod (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  dtlc_pkg::div_ctl_type              ctl_in,
   output dtlc_pkg::div_ctl_type              ctl_out,
   input  wire logic [dtlc_pkg::PHASE_W-1:0]  divisor,
   input  wire logic [dtlc_pkg::PHASE_W-1:0]  dividend,
   output logic [dtlc_pkg::PHASE_W-1:0]       remainder
);
   import dtlc_pkg::*;

   logic               busy_ff, busy_in;
   logic [DIV_CW-1:0]  bit_ff, bit_in;
   logic [PHASE_W-1:0] rem_ff, rem_in;
   logic [PHASE_W-1:0] res_ff, res_in;
   logic [PHASE_W:0]   trial;
   logic [PHASE_W:0]   ival;
   logic [PHASE_W-1:0] step_rem;

   always_comb begin
      ival     = {1'b0, (divisor == '0) ? PHASE_W'(1) : divisor};
      trial    = {rem_ff, dividend[bit_ff]};
      step_rem = (trial >= ival) ? PHASE_W'(trial - ival) : trial[PHASE_W-1:0];
      busy_in  = busy_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      if (ctl_in.start) begin
         busy_in = 1'b1;
         bit_in  = DIV_CW'(PHASE_W - 1);
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = step_rem;
         bit_in = bit_ff - DIV_CW'(1);
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            res_in  = step_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= '0;
         rem_ff  <= '0;
         res_ff  <= LAG_RST;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
         rem_ff  <= rem_in;
         res_ff  <= res_in;
      end
   end

   always_comb begin
      ctl_out.start = ctl_in.start;
      ctl_out.busy  = busy_ff;
      remainder     = res_ff;
   end

endmodule
`default_nettype wire

### src/demand_traffic_light_controller.sv
// Demand-driven traffic light controller for one intersection. Every req transfer
// is one tick carrying the queued car count of each approach (8 bits each); every
// tick yields exactly one rsp transfer with the approach holding green after the
// tick, whether the lights were re-decided, and whether that decision was a ring
// rotation. Four lanes qualify the counts side by side, a two-level merge tree
// picks the busiest approach, and the result lands in an output register that
// lets the next tick enter only while it is empty or being taken. Writing interval
// or lag_phase starts a bit-serial remainder unit that reduces the lag modulo the
// interval; req_tready stays low from the write cycle until the reduction ends.
// After reset the reduced lag is already valid and no such wait is needed.
// Depends on dtlc_pkg, dtlc_lane, dtlc_merge and dtlc_lagmod.
`default_nettype none
module demand_traffic_light_controller (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Tick input
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [dtlc_pkg::REQ_DW-1:0]  req_tdata,  // cars_0, cars_1, cars_2, cars_3
   // Decision output
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [dtlc_pkg::RSP_DW-1:0]       rsp_tdata,  // green_approach[2:0], lights_changed,
                                                         // by_rotation, zero pad
   // Register writes
   input  wire logic                         csr_we,
   input  wire logic [dtlc_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [dtlc_pkg::CSR_DW-1:0]  csr_wdata
);
   import dtlc_pkg::*;

   // Configuration registers
   logic [PHASE_W-1:0] interval_ff, interval_in;
   logic [PHASE_W-1:0] lag_ff, lag_in;
   logic [ROT_W-1:0]   rotate_ff, rotate_in;
   logic [APPR_W-1:0]  num_appr_ff, num_appr_in;

   // Tick state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ROT_W-1:0]   dcount_ff, dcount_in;
   logic [APPR_W-1:0]  green_ff, green_in;

   // Output stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0]  rsp_data_ff, rsp_data_in;

   div_ctl_type        div_req, div_stat;
   logic [PHASE_W-1:0] lag_mod;
   logic               req_fire;
   logic               decide;
   logic               rotate;
   logic [APPR_W-1:0]  n_use;
   logic [APPR_W:0]    ring_next;
   logic [APPR_W-1:0]  ring_green;
   logic [PHASE_W-1:0] ival;
   logic [PHASE_W:0]   phase_next;
   logic [ROT_W-1:0]   every;
   logic [ROT_W:0]     dcount_next;
   logic [LANE_W-1:0]  best_idx;
   logic [CAR_W-1:0]   lane_cars [NUM_LANES];
   cand_type           lane_cand [NUM_LANES];
   csr_reg_type        csr_sel;

   assign csr_sel = csr_reg_type'(csr_addr);

   // A lag or interval write kicks off a fresh reduction
   assign div_req.start = csr_we && ((csr_sel == REG_INTERVAL) || (csr_sel == REG_LAG_PHASE));
   assign div_req.busy  = 1'b0;

   dtlc_lagmod u_lagmod (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (div_req),
      .ctl_out   (div_stat),
      .divisor   (interval_ff),
      .dividend  (lag_ff),
      .remainder (lag_mod)
   );

   // Hold off ticks while the reduced lag is stale; otherwise take one per cycle
   // as long as the output register is free or draining.
   assign req_tready = !div_stat.start && !div_stat.busy && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign n_use = approaches_in_use(num_appr_ff);

   // Demand lanes
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      assign lane_cars[g] = req_tdata[g*CAR_W +: CAR_W];
      dtlc_lane u_lane (
         .cars     (lane_cars[g]),
         .lane_idx (LANE_W'(g)),
         .n_use    (n_use),
         .cand     (lane_cand[g])
      );
   end

   dtlc_merge u_merge (
      .lanes    (lane_cand),
      .best_idx (best_idx)
   );

   always_comb begin
      ival        = (interval_ff == '0) ? PHASE_W'(1) : interval_ff;
      every       = (rotate_ff == '0) ? ROT_W'(1) : rotate_ff;
      decide      = (phase_ff == lag_mod);
      rotate      = decide && (dcount_ff == '0);
      ring_next   = {1'b0, green_ff} + (APPR_W+1)'(1);
      // Step around the ring; past the last approach in use, wrap to approach 1
      ring_green  = ((ring_next > (APPR_W+1)'(n_use)) || (ring_next < (APPR_W+1)'(2)))
                    ? APPR_W'(1) : ring_next[APPR_W-1:0];
      phase_next  = {1'b0, phase_ff} + (PHASE_W+1)'(1);
      dcount_next = {1'b0, dcount_ff} + (ROT_W+1)'(1);
   end

   // Tick state and configuration
   always_comb begin
      interval_in = interval_ff;
      lag_in      = lag_ff;
      rotate_in   = rotate_ff;
      num_appr_in = num_appr_ff;
      phase_in    = phase_ff;
      dcount_in   = dcount_ff;
      green_in    = green_ff;

      if (req_fire) begin
         phase_in = (phase_next >= (PHASE_W+1)'(ival)) ? '0 : phase_next[PHASE_W-1:0];
         if (decide) begin
            green_in  = rotate ? ring_green : APPR_W'(best_idx) + APPR_W'(1);
            dcount_in = (dcount_next >= (ROT_W+1)'(every)) ? '0 : dcount_next[ROT_W-1:0];
         end
      end

      if (csr_we) begin
         case (csr_sel)
            REG_INTERVAL:     interval_in = csr_wdata[PHASE_W-1:0];
            REG_LAG_PHASE:    lag_in      = csr_wdata[PHASE_W-1:0];
            REG_ROTATE_EVERY: rotate_in   = csr_wdata[ROT_W-1:0];
            REG_NUM_APPR:     num_appr_in = csr_wdata[APPR_W-1:0];
            // Initial green also moves the lights at once
            REG_INIT_GREEN:   green_in    = clamp_green(csr_wdata[APPR_W-1:0]);
            default: ;
         endcase
      end
   end

   // Output register: load on a tick, drop once the downstream takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DW-APPR_W-2){1'b0}}, rotate, decide, green_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= INTERVAL_RST;
         lag_ff       <= LAG_RST;
         rotate_ff    <= ROTATE_RST;
         num_appr_ff  <= NUM_APPR_RST;
         phase_ff     <= '0;
         dcount_ff    <= '0;
         green_ff     <= clamp_green(INIT_GREEN_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         lag_ff       <= lag_in;
         rotate_ff    <= rotate_in;
         num_appr_ff  <= num_appr_in;
         phase_ff     <= phase_in;
         dcount_ff    <= dcount_in;
         green_ff     <= green_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### src/dtlc_checker.sv
// Port-level checks for the traffic light controller and the bind that attaches them.
// Depends on dtlc_pkg, assert_macros.svh and demand_traffic_light_controller.
`default_nettype none
`include "assert_macros.svh"
module dtlc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_tready,
   input wire logic                         rsp_tvalid,
   input wire logic                         rsp_tready,
   input wire logic [dtlc_pkg::RSP_DW-1:0]  rsp_tdata,
   input wire logic                         csr_we,
   input wire logic [dtlc_pkg::CSR_AW-1:0]  csr_addr
);
   import dtlc_pkg::*;

   logic [APPR_W-1:0] green_code;
   logic              green_ok;
   logic              lag_write;

   assign green_code = rsp_tdata[APPR_W-1:0];
   assign green_ok   = (green_code != '0) && (green_code <= MAX_APPR_CODE);
   assign lag_write  = csr_we && ((csr_addr == REG_INTERVAL) || (csr_addr == REG_LAG_PHASE));

   // A stalled result holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // Rotation is only ever reported on a decision tick
   `ASSERT_ALWAYS(a_rot_needs_change, clock, reset, !rsp_tvalid || !rsp_tdata[4] || rsp_tdata[3])

   // Green always names an approach that exists
   `ASSERT_ALWAYS(a_green_range, clock, reset, !rsp_tvalid || green_ok)

   // Changing the interval or lag stalls ticks while the lag is reduced again
   `ASSERT_NEXT(a_lag_stall, clock, reset, lag_write, !req_tready)

endmodule

bind demand_traffic_light_controller dtlc_checker u_dtlc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_we     (csr_we),
   .csr_addr   (csr_addr)
);
`default_nettype wire
